@@ sv/fhid_pkg.sv @@
// Shared types, codes and helper functions for the frame history invalidation detector.
package fhid_pkg;

   localparam logic [1:0] CMD_CUT   = 2'd0;
   localparam logic [1:0] CMD_PROJ  = 2'd1;
   localparam logic [1:0] CMD_FRAME = 2'd2;

   localparam logic [2:0] CAUSE_NONE       = 3'd0;
   localparam logic [2:0] CAUSE_TELEPORT   = 3'd2;
   localparam logic [2:0] CAUSE_PROJECTION = 3'd3;
   localparam logic [2:0] CAUSE_RESOLUTION = 3'd4;
   localparam logic [2:0] CAUSE_UNDEFINED  = 3'd7;

   localparam int CAUSE_COUNT = 7;
   localparam int AXES        = 3;

   localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

   typedef struct packed {
      logic [2:0]  pending;
      logic        first;
      logic        resized;
      logic        proj_changed;
      logic [31:0] frame_number;
   } frame_flags_type;

   typedef logic [AXES-1:0][31:0] axis_diff_type;
   typedef logic [AXES-1:0][63:0] axis_square_type;

   // prime is 2^40 + 0x1b3, so the multiply is a handful of shifted adds
   function automatic logic [63:0] fnv_step(input logic [63:0] hash, input logic [31:0] word);
      logic [63:0] x;
      x = hash ^ {32'd0, word};
      return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
   endfunction

   // magnitude of a difference of two signed 32-bit values, always below 2^32
   function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] d;
      logic [32:0] m;
      d = {a[31], a} - {b[31], b};
      m = d[32] ? (~d + 33'd1) : d;
      return m[31:0];
   endfunction

endpackage

@@ sv/fhid_if.sv @@
// Valid/ready channel interfaces for the request and result items.
interface fhid_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic [2:0]         cut_cause;
   logic [31:0]        proj_word;
   logic [15:0]        frame_width;
   logic [15:0]        frame_height;
   logic signed [31:0] cam_x;
   logic signed [31:0] cam_y;
   logic signed [31:0] cam_z;

   modport source (output valid, command, cut_cause, proj_word, frame_width, frame_height,
                   cam_x, cam_y, cam_z, input ready);
   modport sink (input valid, command, cut_cause, proj_word, frame_width, frame_height,
                 cam_x, cam_y, cam_z, output ready);
endinterface

interface fhid_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  frame_cause;
   logic        was_resized;
   logic [31:0] frame_number;
   logic [31:0] cause_count;
   logic [31:0] last_invalid_frame;

   modport source (output valid, frame_cause, was_resized, frame_number, cause_count,
                   last_invalid_frame, input ready);
   modport sink (input valid, frame_cause, was_resized, frame_number, cause_count,
                 last_invalid_frame, output ready);
endinterface

@@ sv/fhid_front.sv @@
// Input register, frame history state, projection hash and per-frame compare stage.
module fhid_front (
   input  logic                      clock,
   input  logic                      reset,
   fhid_req_if.sink                  req,
   output logic                      out_valid,
   input  logic                      out_ready,
   output fhid_pkg::frame_flags_type out_flags,
   output fhid_pkg::axis_diff_type   out_diff
);

   logic                    in_valid_ff;
   logic [1:0]              in_command_ff;
   logic [2:0]              in_cut_ff;
   logic [31:0]             in_word_ff;
   logic [15:0]             in_width_ff;
   logic [15:0]             in_height_ff;
   fhid_pkg::axis_diff_type in_pos_ff;

   logic [2:0]              pending_ff;
   logic [31:0]             counter_ff;
   logic                    seen_ff;
   logic [15:0]             prev_width_ff;
   logic [15:0]             prev_height_ff;
   fhid_pkg::axis_diff_type prev_pos_ff;
   logic [63:0]             key_ff;
   logic [63:0]             hash_ff;

   logic                      out_valid_ff;
   fhid_pkg::frame_flags_type flags_ff;
   fhid_pkg::axis_diff_type   diff_ff;

   logic                      is_frame;
   logic                      out_load;
   logic                      in_adv;
   logic                      in_load;
   logic                      first;
   logic                      resized;
   fhid_pkg::frame_flags_type flags_in;
   fhid_pkg::axis_diff_type   diff_in;
   logic [2:0]                pending_in;
   logic [63:0]               hash_in;

   assign is_frame  = in_command_ff == fhid_pkg::CMD_FRAME;
   assign out_load  = !out_valid_ff || out_ready;
   // non-frame items finish here and never wait on the stages behind
   assign in_adv    = in_valid_ff && (!is_frame || out_load);
   assign in_load   = !in_valid_ff || in_adv;
   assign req.ready = in_load;

   assign first   = !seen_ff;
   assign resized = !first && (in_width_ff != prev_width_ff || in_height_ff != prev_height_ff);

   always_comb begin
      flags_in.pending      = pending_ff;
      flags_in.first        = first;
      flags_in.resized      = resized;
      flags_in.proj_changed = !first && !resized && (hash_ff != key_ff);
      flags_in.frame_number = counter_ff + 32'd1;
      for (int i = 0; i < fhid_pkg::AXES; i++) begin
         diff_in[i] = fhid_pkg::abs_diff(in_pos_ff[i], prev_pos_ff[i]);
      end
   end

   always_comb begin
      pending_in = pending_ff;
      hash_in    = hash_ff;
      case (in_command_ff)
         fhid_pkg::CMD_CUT: begin
            if (in_cut_ff != fhid_pkg::CAUSE_UNDEFINED) begin
               pending_in = in_cut_ff;
            end
         end
         fhid_pkg::CMD_PROJ: begin
            hash_in = fhid_pkg::fnv_step(hash_ff, in_word_ff);
         end
         fhid_pkg::CMD_FRAME: begin
            pending_in = fhid_pkg::CAUSE_NONE;
            hash_in    = fhid_pkg::FNV_BASIS;
         end
         default: begin
            pending_in = pending_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         pending_ff     <= fhid_pkg::CAUSE_NONE;
         counter_ff     <= 32'd0;
         seen_ff        <= 1'b0;
         prev_width_ff  <= 16'd0;
         prev_height_ff <= 16'd0;
         prev_pos_ff    <= '0;
         key_ff         <= 64'd0;
         hash_ff        <= fhid_pkg::FNV_BASIS;
      end else begin
         if (in_load) begin
            in_valid_ff <= req.valid;
         end
         if (out_load) begin
            out_valid_ff <= in_adv && is_frame;
         end
         if (in_adv) begin
            pending_ff <= pending_in;
            hash_ff    <= hash_in;
            if (is_frame) begin
               counter_ff     <= flags_in.frame_number;
               seen_ff        <= 1'b1;
               prev_width_ff  <= in_width_ff;
               prev_height_ff <= in_height_ff;
               prev_pos_ff    <= in_pos_ff;
               key_ff         <= hash_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_command_ff <= req.command;
         in_cut_ff     <= req.cut_cause;
         in_word_ff    <= req.proj_word;
         in_width_ff   <= req.frame_width;
         in_height_ff  <= req.frame_height;
         in_pos_ff     <= {req.cam_z, req.cam_y, req.cam_x};
      end
      if (out_load && in_adv && is_frame) begin
         flags_ff <= flags_in;
         diff_ff  <= diff_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_flags = flags_ff;
   assign out_diff  = diff_ff;

endmodule

@@ sv/fhid_motion.sv @@
// Camera move check: squared axis distances summed against the squared threshold.
module fhid_motion (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [31:0]               csr_write_data,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  fhid_pkg::frame_flags_type in_flags,
   input  fhid_pkg::axis_diff_type   in_diff,
   output logic                      out_valid,
   input  logic                      out_ready,
   output fhid_pkg::frame_flags_type out_flags,
   output logic                      out_teleported
);

   logic [63:0]               lim_ff;
   logic [63:0]               lim_in;

   logic                      sq_valid_ff;
   fhid_pkg::frame_flags_type sq_flags_ff;
   fhid_pkg::axis_square_type sq_ff;
   fhid_pkg::axis_square_type sq_in;

   logic                      tp_valid_ff;
   fhid_pkg::frame_flags_type tp_flags_ff;
   logic                      tp_ff;

   logic                      tp_load;
   logic                      sq_load;
   logic [65:0]               sum_in;
   logic                      tp_in;

   assign lim_in = {32'd0, csr_write_data} * {32'd0, csr_write_data};

   always_comb begin
      for (int i = 0; i < fhid_pkg::AXES; i++) begin
         sq_in[i] = {32'd0, in_diff[i]} * {32'd0, in_diff[i]};
      end
   end

   assign tp_load  = !tp_valid_ff || out_ready;
   assign sq_load  = !sq_valid_ff || tp_load;
   assign in_ready = sq_load;

   assign sum_in = {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
   assign tp_in  = !sq_flags_ff.first && (sum_in > {2'b00, lim_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff      <= 64'd0;
         sq_valid_ff <= 1'b0;
         tp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            lim_ff <= lim_in;
         end
         if (sq_load) begin
            sq_valid_ff <= in_valid;
         end
         if (tp_load) begin
            tp_valid_ff <= sq_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sq_load) begin
         sq_flags_ff <= in_flags;
         sq_ff       <= sq_in;
      end
      if (tp_load) begin
         tp_flags_ff <= sq_flags_ff;
         tp_ff       <= tp_in;
      end
   end

   assign out_valid      = tp_valid_ff;
   assign out_flags      = tp_flags_ff;
   assign out_teleported = tp_ff;

endmodule

@@ sv/fhid_tally.sv @@
// Cause priority, per-cause counters and the result register.
module fhid_tally (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  fhid_pkg::frame_flags_type in_flags,
   input  logic                      in_teleported,
   fhid_rsp_if.source                rsp
);

   logic [fhid_pkg::CAUSE_COUNT-1:0][31:0] counters_ff;
   logic [31:0]                            last_hit_ff;

   logic        rsp_valid_ff;
   logic [2:0]  cause_ff;
   logic        resized_ff;
   logic [31:0] number_ff;
   logic [31:0] count_ff;
   logic [31:0] last_ff;

   logic        out_load;
   logic        take;
   logic [2:0]  cause_in;
   logic [31:0] count_in;
   logic [31:0] last_in;

   assign out_load = !rsp_valid_ff || rsp.ready;
   assign in_ready = out_load;
   assign take     = in_valid && out_load;

   always_comb begin
      if (in_flags.pending != fhid_pkg::CAUSE_NONE) begin
         cause_in = in_flags.pending;
      end else if (in_flags.resized) begin
         cause_in = fhid_pkg::CAUSE_RESOLUTION;
      end else if (in_teleported) begin
         cause_in = fhid_pkg::CAUSE_TELEPORT;
      end else if (in_flags.proj_changed) begin
         cause_in = fhid_pkg::CAUSE_PROJECTION;
      end else begin
         cause_in = fhid_pkg::CAUSE_NONE;
      end
   end

   // cause none is never counted and reports zero
   always_comb begin
      count_in = 32'd0;
      for (int i = 1; i < fhid_pkg::CAUSE_COUNT; i++) begin
         if (cause_in == 3'(i)) begin
            count_in = counters_ff[i] + 32'd1;
         end
      end
   end

   assign last_in = (cause_in != fhid_pkg::CAUSE_NONE) ? in_flags.frame_number : last_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         counters_ff  <= '0;
         last_hit_ff  <= 32'd0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= in_valid;
         end
         if (take) begin
            last_hit_ff <= last_in;
            for (int i = 1; i < fhid_pkg::CAUSE_COUNT; i++) begin
               if (cause_in == 3'(i)) begin
                  counters_ff[i] <= count_in;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cause_ff   <= cause_in;
         resized_ff <= in_flags.resized;
         number_ff  <= in_flags.frame_number;
         count_ff   <= count_in;
         last_ff    <= last_in;
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.frame_cause        = cause_ff;
   assign rsp.was_resized        = resized_ff;
   assign rsp.frame_number       = number_ff;
   assign rsp.cause_count        = count_ff;
   assign rsp.last_invalid_frame = last_ff;

endmodule

@@ sv/frame_history_invalidation_detector.sv @@
// Frame history invalidation detector top level.
//
// req_chan takes one item per cycle unless stalled: a cut signal (records a
// pending cause), a projection word (folded into the 64-bit projection hash)
// or a begin-frame item. Only begin-frame items produce a result on rsp_chan:
// the invalidation cause, the resize flag, the frame number, the count for that
// cause and the last invalidated frame number. Cut and projection items produce nothing.
// csr_write_enable/csr_write_data load the teleport distance (unsigned Q16.16);
// write it only while no frame is in flight.
// A frame item's result passes the input register, compare stage, square
// multipliers, sum compare and result register in order. Throughput: one item
// per cycle while rsp_chan does not stall; the three 32x32 square units and
// the combinational hash fold set that rate.
// Reset clears the pending cause, counters and stored frame, returns the hash to
// the offset basis and the threshold to zero; the first frame after reset only
// honors a pending cause.
// When rsp_chan stalls, the stages fill behind the held result; req_chan.ready
// stays high until every stage that a frame item needs is occupied.
module frame_history_invalidation_detector (
   input  logic        clock,
   input  logic        reset,
   fhid_req_if.sink    req_chan,
   fhid_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   logic                      cmp_valid;
   logic                      cmp_ready;
   fhid_pkg::frame_flags_type cmp_flags;
   fhid_pkg::axis_diff_type   cmp_diff;

   logic                      mot_valid;
   logic                      mot_ready;
   fhid_pkg::frame_flags_type mot_flags;
   logic                      mot_teleported;

   fhid_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .out_valid (cmp_valid),
      .out_ready (cmp_ready),
      .out_flags (cmp_flags),
      .out_diff  (cmp_diff)
   );

   fhid_motion u_motion (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .in_valid         (cmp_valid),
      .in_ready         (cmp_ready),
      .in_flags         (cmp_flags),
      .in_diff          (cmp_diff),
      .out_valid        (mot_valid),
      .out_ready        (mot_ready),
      .out_flags        (mot_flags),
      .out_teleported   (mot_teleported)
   );

   fhid_tally u_tally (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (mot_valid),
      .in_ready      (mot_ready),
      .in_flags      (mot_flags),
      .in_teleported (mot_teleported),
      .rsp           (rsp_chan)
   );

endmodule

@@ sv/fhid_checker.sv @@
// Port-level checks for the frame history invalidation detector, bound to the top level.
module fhid_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_command,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_frame_cause,
   input logic [31:0] rsp_frame_number,
   input logic [31:0] rsp_cause_count,
   input logic [31:0] rsp_last_invalid_frame
);

   logic [3:0]  in_flight_ff;
   logic        have_result_ff;
   logic [31:0] last_number_ff;
   logic [31:0] last_invalid_ff;

   logic frame_in;
   logic result_out;

   assign frame_in   = req_valid && req_ready && req_command == fhid_pkg::CMD_FRAME;
   assign result_out = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff   <= 4'd0;
         have_result_ff <= 1'b0;
      end else begin
         in_flight_ff <= in_flight_ff + {3'd0, frame_in} - {3'd0, result_out};
         if (result_out) begin
            have_result_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (result_out) begin
         last_number_ff  <= rsp_frame_number;
         last_invalid_ff <= rsp_last_invalid_frame;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> in_flight_ff != 4'd0)
      else $error("result without an accepted frame item");

   a_frame_order: assert property (@(posedge clock) disable iff (reset)
      result_out && have_result_ff |-> rsp_frame_number == last_number_ff + 32'd1)
      else $error("frame number not consecutive");

   a_none_keeps: assert property (@(posedge clock) disable iff (reset)
      result_out && have_result_ff && rsp_frame_cause == fhid_pkg::CAUSE_NONE |->
         rsp_cause_count == 32'd0 && rsp_last_invalid_frame == last_invalid_ff)
      else $error("frame without cause changed invalidation record");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_number)
         && $stable(rsp_frame_cause) && $stable(rsp_cause_count))
      else $error("stalled result changed");

endmodule

bind frame_history_invalidation_detector fhid_checker u_fhid_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_chan.valid),
   .req_ready              (req_chan.ready),
   .req_command            (req_chan.command),
   .rsp_valid              (rsp_chan.valid),
   .rsp_ready              (rsp_chan.ready),
   .rsp_frame_cause        (rsp_chan.frame_cause),
   .rsp_frame_number       (rsp_chan.frame_number),
   .rsp_cause_count        (rsp_chan.cause_count),
   .rsp_last_invalid_frame (rsp_chan.last_invalid_frame)
);

@@ tb/frame_history_invalidation_detector_tb.sv @@
// Self-checking testbench for the frame history invalidation detector.
module frame_history_invalidation_detector_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0]  CMD_UNDEFINED  = 2'd3;
   localparam logic [2:0]  CAUSE_CUT      = 3'd1;
   localparam logic [2:0]  CAUSE_SCENE    = 3'd5;
   localparam logic [2:0]  CAUSE_EXPLICIT = 3'd6;
   localparam logic [63:0] HASH_PRIME     = 64'd1099511628211;
   localparam int          SETTLE_CYCLES  = 10;
   localparam int          PHASE_ITEMS    = 170;

   typedef struct packed {
      logic [1:0]  command;
      logic [2:0]  cut_cause;
      logic [31:0] proj_word;
      logic [15:0] frame_width;
      logic [15:0] frame_height;
      logic [31:0] cam_x;
      logic [31:0] cam_y;
      logic [31:0] cam_z;
   } detector_item_type;

   typedef struct packed {
      logic [2:0]  frame_cause;
      logic        was_resized;
      logic [31:0] frame_number;
      logic [31:0] cause_count;
      logic [31:0] last_invalid_frame;
   } verdict_type;

   typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_BURSTY} stall_mode_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;

   fhid_req_if req_chan ();
   fhid_rsp_if rsp_chan ();

   frame_history_invalidation_detector i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   detector_item_type items_to_send[$];
   verdict_type       verdicts_due[$];
   int                sent_total = 0;
   int                useful_count = 0;
   int                accepted_count = 0;
   int                failures = 0;

   // history tracked by the checker
   logic [31:0] hist_distance;
   logic [2:0]  hist_pending;
   logic [31:0] hist_frames;
   logic        hist_seen;
   logic [15:0] hist_width;
   logic [15:0] hist_height;
   logic [31:0] hist_pos [fhid_pkg::AXES];
   logic [63:0] hist_key;
   logic [63:0] hist_hash;
   logic [31:0] hist_cause_hits [fhid_pkg::CAUSE_COUNT];
   logic [31:0] hist_last_hit;

   // stimulus-side view of the scene
   logic [31:0] gen_distance;
   logic [15:0] gen_width;
   logic [15:0] gen_height;
   logic [31:0] gen_cam [fhid_pkg::AXES];
   logic [31:0] gen_matrix [16];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic apply_to_history(input detector_item_type it);
      logic [31:0]        cam [fhid_pkg::AXES];
      logic signed [32:0] diff;
      logic [32:0]        mag;
      logic [66:0]        dist_sq;
      logic               first, resized, proj_changed, teleported;
      logic [2:0]         cause;
      verdict_type        v;
      int                 axis;
      cam[0] = it.cam_x;
      cam[1] = it.cam_y;
      cam[2] = it.cam_z;
      case (it.command)
         fhid_pkg::CMD_CUT: begin
            if (it.cut_cause != fhid_pkg::CAUSE_UNDEFINED) hist_pending = it.cut_cause;
         end
         fhid_pkg::CMD_PROJ: begin
            hist_hash = (hist_hash ^ {32'd0, it.proj_word}) * HASH_PRIME;
         end
         fhid_pkg::CMD_FRAME: begin
            dist_sq = '0;
            for (axis = 0; axis < fhid_pkg::AXES; axis++) begin
               diff = $signed({cam[axis][31], cam[axis]})
                      - $signed({hist_pos[axis][31], hist_pos[axis]});
               mag = diff[32] ? 33'(-diff) : 33'(diff);
               dist_sq = dist_sq + 67'(mag) * 67'(mag);
            end
            hist_frames  = hist_frames + 1;
            first        = !hist_seen;
            resized      = !first && (it.frame_width != hist_width ||
                                      it.frame_height != hist_height);
            proj_changed = !first && !resized && hist_hash != hist_key;
            teleported   = !first && dist_sq > 67'(hist_distance) * 67'(hist_distance);
            if (hist_pending != fhid_pkg::CAUSE_NONE) cause = hist_pending;
            else if (resized) cause = fhid_pkg::CAUSE_RESOLUTION;
            else if (teleported) cause = fhid_pkg::CAUSE_TELEPORT;
            else if (proj_changed) cause = fhid_pkg::CAUSE_PROJECTION;
            else cause = fhid_pkg::CAUSE_NONE;
            hist_pending = fhid_pkg::CAUSE_NONE;
            hist_key     = hist_hash;
            hist_hash    = fhid_pkg::FNV_BASIS;
            hist_seen    = 1'b1;
            hist_width   = it.frame_width;
            hist_height  = it.frame_height;
            for (axis = 0; axis < fhid_pkg::AXES; axis++) hist_pos[axis] = cam[axis];
            v.frame_cause  = cause;
            v.was_resized  = resized;
            v.frame_number = hist_frames;
            v.cause_count  = '0;
            if (cause != fhid_pkg::CAUSE_NONE) begin
               hist_cause_hits[cause] = hist_cause_hits[cause] + 1;
               v.cause_count = hist_cause_hits[cause];
               hist_last_hit = hist_frames;
            end
            v.last_invalid_frame = hist_last_hit;
            verdicts_due.insert(verdicts_due.size(), v);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      detector_item_type seen;
      if (reset) begin
         hist_distance = '0;
         hist_pending  = fhid_pkg::CAUSE_NONE;
         hist_frames   = '0;
         hist_seen     = 1'b0;
         hist_width    = '0;
         hist_height   = '0;
         hist_key      = '0;
         hist_hash     = fhid_pkg::FNV_BASIS;
         hist_last_hit = '0;
         foreach (hist_pos[a]) hist_pos[a] = '0;
         foreach (hist_cause_hits[c]) hist_cause_hits[c] = '0;
      end else begin
         if (csr_write_enable) hist_distance = csr_write_data;
         if (req_chan.valid && req_chan.ready) begin
            seen.command      = req_chan.command;
            seen.cut_cause    = req_chan.cut_cause;
            seen.proj_word    = req_chan.proj_word;
            seen.frame_width  = req_chan.frame_width;
            seen.frame_height = req_chan.frame_height;
            seen.cam_x        = req_chan.cam_x;
            seen.cam_y        = req_chan.cam_y;
            seen.cam_z        = req_chan.cam_z;
            apply_to_history(seen);
            accepted_count++;
         end
      end
   end

   // sender: bursts of random length separated by random gaps
   detector_item_type next_item;
   int                gap_left;
   int                burst_left;

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         gap_left       <= 0;
         burst_left     <= 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (gap_left != 0 || items_to_send.size() == 0) begin
            req_chan.valid <= 1'b0;
            if (gap_left != 0) gap_left <= gap_left - 1;
         end else begin
            next_item = items_to_send.pop_front();
            req_chan.valid        <= 1'b1;
            req_chan.command      <= next_item.command;
            req_chan.cut_cause    <= next_item.cut_cause;
            req_chan.proj_word    <= next_item.proj_word;
            req_chan.frame_width  <= next_item.frame_width;
            req_chan.frame_height <= next_item.frame_height;
            req_chan.cam_x        <= next_item.cam_x;
            req_chan.cam_y        <= next_item.cam_y;
            req_chan.cam_z        <= next_item.cam_z;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // receiver: a random stall pattern, redrawn on a free-running tick counter
   stall_mode_type stall_mode;
   logic [31:0]    stall_tick;

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_mode     <= STALL_NONE;
         stall_tick     <= '0;
      end else begin
         stall_tick <= stall_tick + 1;
         if (stall_tick[5:0] == 6'd0) stall_mode <= stall_mode_type'($urandom_range(0, 3));
         case (stall_mode)
            STALL_NONE:   rsp_chan.ready <= 1'b1;
            STALL_COIN:   rsp_chan.ready <= 1'($urandom_range(0, 1));
            STALL_SPARSE: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            default:      rsp_chan.ready <= (stall_tick[3:0] == 4'd0);
         endcase
      end
   end

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (verdicts_due.size() == 0) begin
            $error("result with none outstanding: frame_number %0d", rsp_chan.frame_number);
            failures++;
         end else begin
            want = verdicts_due.pop_front();
            compare_field("frame_cause", 32'(want.frame_cause), 32'(rsp_chan.frame_cause));
            compare_field("was_resized", 32'(want.was_resized), 32'(rsp_chan.was_resized));
            compare_field("frame_number", want.frame_number, rsp_chan.frame_number);
            compare_field("cause_count", want.cause_count, rsp_chan.cause_count);
            compare_field("last_invalid_frame", want.last_invalid_frame,
                          rsp_chan.last_invalid_frame);
         end
      end
   end

   function automatic detector_item_type random_item();
      detector_item_type it;
      it.command      = 2'($urandom_range(0, 3));
      it.cut_cause    = 3'($urandom_range(0, 7));
      it.proj_word    = $urandom;
      it.frame_width  = 16'($urandom);
      it.frame_height = 16'($urandom);
      it.cam_x        = $urandom;
      it.cam_y        = $urandom;
      it.cam_z        = $urandom;
      return it;
   endfunction

   task automatic queue_item(input detector_item_type it);
      items_to_send.insert(items_to_send.size(), it);
      sent_total++;
      if (it.command != CMD_UNDEFINED &&
          !(it.command == fhid_pkg::CMD_CUT && it.cut_cause == fhid_pkg::CAUSE_UNDEFINED))
         useful_count++;
   endtask

   task automatic push_cut(input logic [2:0] cause);
      detector_item_type it;
      it = random_item();
      it.command   = fhid_pkg::CMD_CUT;
      it.cut_cause = cause;
      queue_item(it);
   endtask

   task automatic push_word(input logic [31:0] word);
      detector_item_type it;
      it = random_item();
      it.command   = fhid_pkg::CMD_PROJ;
      it.proj_word = word;
      queue_item(it);
   endtask

   task automatic push_frame(input logic [15:0] w, input logic [15:0] h,
                             input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
      detector_item_type it;
      it = random_item();
      it.command      = fhid_pkg::CMD_FRAME;
      it.frame_width  = w;
      it.frame_height = h;
      it.cam_x        = x;
      it.cam_y        = y;
      it.cam_z        = z;
      gen_width  = w;
      gen_height = h;
      gen_cam[0] = x;
      gen_cam[1] = y;
      gen_cam[2] = z;
      queue_item(it);
   endtask

   task automatic set_distance(input logic [31:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      gen_distance = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // sender holds off until every outstanding result is back
   task automatic finish_phase();
      while (accepted_count != sent_total || verdicts_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic add_sequence();
      detector_item_type it;
      logic [31:0]       cam [fhid_pkg::AXES];
      logic [31:0]       off;
      int                words, k, a, n;
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 6);
         for (k = 0; k < n; k++) begin
            it = random_item();
            queue_item(it);
         end
      end else begin
         if ($urandom_range(0, 4) == 0) push_cut(3'($urandom_range(0, 7)));
         case ($urandom_range(0, 7))
            0: gen_matrix[$urandom_range(0, 15)] = $urandom;
            1: foreach (gen_matrix[m]) gen_matrix[m] = $urandom;
            default: ;
         endcase
         words = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : 16;
         for (k = 0; k < words; k++) push_word(gen_matrix[k % 16]);
         case ($urandom_range(0, 9))
            0: gen_width = 16'($urandom);
            1: gen_height = 16'($urandom);
            2: begin
               gen_width  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               gen_height = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
            default: ;
         endcase
         foreach (cam[i]) cam[i] = gen_cam[i];
         case ($urandom_range(0, 4))
            2: begin
               for (a = 0; a < fhid_pkg::AXES; a++) begin
                  off = $urandom_range(0, gen_distance);
                  if ($urandom_range(0, 1)) off = -off;
                  cam[a] = cam[a] + off;
               end
            end
            3: begin
               a   = $urandom_range(0, fhid_pkg::AXES - 1);
               off = gen_distance + $urandom_range(0, 1);
               if ($urandom_range(0, 1)) off = -off;
               cam[a] = cam[a] + off;
            end
            4: foreach (cam[i]) cam[i] = $urandom;
            default: ;
         endcase
         push_frame(gen_width, gen_height, cam[0], cam[1], cam[2]);
      end
   endtask

   initial begin
      logic [31:0]       phase_distance [4];
      int                p, target;
      detector_item_type odd;
      req_chan.valid        = 1'b0;
      req_chan.command      = fhid_pkg::CMD_CUT;
      req_chan.cut_cause    = fhid_pkg::CAUSE_NONE;
      req_chan.proj_word    = '0;
      req_chan.frame_width  = '0;
      req_chan.frame_height = '0;
      req_chan.cam_x        = '0;
      req_chan.cam_y        = '0;
      req_chan.cam_z        = '0;
      rsp_chan.ready        = 1'b0;
      gen_width  = '0;
      gen_height = '0;
      foreach (gen_cam[i]) gen_cam[i] = '0;
      foreach (gen_matrix[m]) gen_matrix[m] = $urandom;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: threshold of 1.0
      set_distance(32'h0001_0000);
      push_cut(CAUSE_SCENE);
      push_word(32'h0000_0000);
      push_word(32'hFFFF_FFFF);
      push_frame(16'h0000, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
      push_frame(16'h0000, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
      push_frame(16'h0000, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
      push_frame(16'hFFFF, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
      push_frame(16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
      push_cut(fhid_pkg::CAUSE_TELEPORT);
      push_cut(fhid_pkg::CAUSE_UNDEFINED);
      push_frame(16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
      push_cut(CAUSE_EXPLICIT);
      push_cut(fhid_pkg::CAUSE_NONE);
      push_frame(16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
      odd = random_item();
      odd.command = CMD_UNDEFINED;
      queue_item(odd);
      // largest possible move on the x and y axes
      push_frame(16'hFFFF, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      // exactly at the threshold, then one step past it
      push_frame(16'hFFFF, 16'hFFFF, 32'h8001_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      push_frame(16'hFFFF, 16'hFFFF, 32'h8002_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      push_cut(CAUSE_CUT);
      push_cut(fhid_pkg::CAUSE_PROJECTION);
      push_frame(16'd1920, 16'd1080, 32'h8002_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      // resize, move and new key together: resize wins
      push_word(32'h3F80_0000);
      push_frame(16'd1280, 16'd720, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      push_cut(fhid_pkg::CAUSE_RESOLUTION);
      push_frame(16'd1280, 16'd720, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      finish_phase();

      phase_distance[0] = 32'hFFFF_FFFF;
      phase_distance[1] = 32'h0000_0000;
      phase_distance[2] = $urandom;
      phase_distance[3] = {12'h000, 20'($urandom)};
      for (p = 0; p < 4; p++) begin
         set_distance(phase_distance[p]);
         target = useful_count + PHASE_ITEMS;
         while (useful_count < target) add_sequence();
         finish_phase();
      end

      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ files.f @@
sv/fhid_pkg.sv
sv/fhid_if.sv
sv/fhid_front.sv
sv/fhid_motion.sv
sv/fhid_tally.sv
sv/frame_history_invalidation_detector.sv
sv/fhid_checker.sv
tb/frame_history_invalidation_detector_tb.sv
